FILE: hw/rtl/motor_command_frame_decoder_defines.svh
// assertion macros shared by the motor command frame decoder rtl
`ifndef MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is held
`define MCFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcfd assertion failed");

// next-cycle implication, disabled while reset is held
`define MCFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcfd assertion failed");

`else

`define MCFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/mcfd_pkg.sv
// types, constants and mode decode for the motor command frame decoder
package mcfd_pkg;

    localparam int WIN_LEN = 9;
    localparam int MOTORS  = 4;

    localparam logic [7:0] WIN_FIRST_RST = 8'h66;
    localparam logic [7:0] WIN_LAST_RST  = 8'h99;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_SLOW_SPEED   = 2'd2;
    localparam logic [1:0] CFG_FAST_SPEED   = 2'd3;

    localparam logic [7:0] START_MARKER_RST = 8'h66;
    localparam logic [7:0] END_MARKER_RST   = 8'h99;
    localparam logic [7:0] SLOW_SPEED_RST   = 8'd100;
    localparam logic [7:0] FAST_SPEED_RST   = 8'd255;

    // motor directions
    localparam logic [1:0] DIR_RELEASED = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;

    // mode nibble codes
    localparam logic [3:0] MODE_RELEASE  = 4'd0;
    localparam logic [3:0] MODE_FWD_STOP = 4'd1;
    localparam logic [3:0] MODE_FWD_SLOW = 4'd2;
    localparam logic [3:0] MODE_FWD_FAST = 4'd3;
    localparam logic [3:0] MODE_BWD_STOP = 4'd4;
    localparam logic [3:0] MODE_BWD_SLOW = 4'd5;
    localparam logic [3:0] MODE_BWD_FAST = 4'd6;

    typedef struct packed {
        logic [1:0] dir;
        logic [7:0] speed;
    } t_motor;

    // mode nibble, then speed byte override
    function automatic t_motor motor_update(
        input t_motor     old_m,
        input logic [3:0] mode,
        input logic [7:0] spd_byte,
        input logic [7:0] slow,
        input logic [7:0] fast
    );
        t_motor m;
        m = old_m;
        case (mode)
            MODE_RELEASE:  begin m.dir = DIR_RELEASED; m.speed = 8'd0; end
            MODE_FWD_STOP: begin m.dir = DIR_FORWARD;  m.speed = 8'd0; end
            MODE_FWD_SLOW: begin m.dir = DIR_FORWARD;  m.speed = slow; end
            MODE_FWD_FAST: begin m.dir = DIR_FORWARD;  m.speed = fast; end
            MODE_BWD_STOP: begin m.dir = DIR_BACKWARD; m.speed = 8'd0; end
            MODE_BWD_SLOW: begin m.dir = DIR_BACKWARD; m.speed = slow; end
            MODE_BWD_FAST: begin m.dir = DIR_BACKWARD; m.speed = fast; end
            default:       m = old_m;
        endcase
        if (spd_byte != 8'd0 && m.dir != DIR_RELEASED) begin
            m.speed = spd_byte;
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/motor_command_frame_decoder.sv
// motor command frame decoder top level
// Takes one received byte per request on the rx channel and shifts it into a
// nine-byte window. When the window starts with the start marker, ends with the
// end marker, and its eighth byte equals the xor of bytes two to seven, the
// frame is decoded: four mode nibbles (motor one in the high nibble of the
// second byte) set direction and preset speed, mode codes 7 to 15 keep the
// motor's previous setting, and a nonzero speed byte overrides the speed of any
// motor that is not released. Each good frame gives one result request with
// all four directions and speeds; other bytes give none. A byte is decoded in
// the cycle it is taken, and the result appears in the output register in the
// next cycle, so the block takes one byte per clock as long as the result side
// drains; rx ready drops only while a result is held and not taken. The user must
// write configuration through the plain write port only while idle, which the
// block does not enforce; marker/speed registers reset to 0x66, 0x99, 100, 255.
`include "motor_command_frame_decoder_defines.svh"

module motor_command_frame_decoder
    import mcfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,

    // received byte channel
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,

    // decoded frame channel
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_dir_one,
    output logic [7:0] o_speed_one,
    output logic [1:0] o_dir_two,
    output logic [7:0] o_speed_two,
    output logic [1:0] o_dir_three,
    output logic [7:0] o_speed_three,
    output logic [1:0] o_dir_four,
    output logic [7:0] o_speed_four
);

    // configuration registers
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic [7:0] r_slow_speed;
    logic [7:0] r_fast_speed;

    // byte window, index 0 is the oldest byte
    logic [7:0] r_win [WIN_LEN];
    logic [7:0] n_win [WIN_LEN];

    // motor state and result register
    t_motor     r_motor [MOTORS];
    t_motor     n_motor [MOTORS];
    t_motor     r_out   [MOTORS];
    logic       r_res_valid;

    logic       w_rx_acc;
    logic       w_frame_ok;
    logic [7:0] w_check;
    logic       w_released_ok;

    // a byte may enter whenever the result register is empty or draining
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign w_rx_acc   = i_rx_valid && o_rx_ready;

    // window as it stands once the new byte is shifted in
    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            n_win[k] = r_win[k + 1];
        end
        n_win[WIN_LEN - 1] = i_rx_byte;
    end

    // frame check on the shifted window
    assign w_check = n_win[1] ^ n_win[2] ^ n_win[3] ^ n_win[4] ^ n_win[5] ^ n_win[6];
    assign w_frame_ok = (n_win[0] == r_start_marker)
                     && (n_win[WIN_LEN - 1] == r_end_marker)
                     && (w_check == n_win[7]);

    // per motor decode: even motors use the high nibble
    always_comb begin
        for (int m = 0; m < MOTORS; m++) begin
            n_motor[m] = motor_update(
                r_motor[m],
                (m % 2 == 0) ? n_win[1 + m / 2][7:4] : n_win[1 + m / 2][3:0],
                n_win[3 + m],
                r_slow_speed,
                r_fast_speed
            );
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
            r_slow_speed   <= SLOW_SPEED_RST;
            r_fast_speed   <= FAST_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                CFG_SLOW_SPEED:   r_slow_speed   <= i_cfg_wdata;
                CFG_FAST_SPEED:   r_fast_speed   <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    // window shift, motor state commit and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= WIN_FIRST_RST;
            for (int k = 1; k < WIN_LEN - 1; k++) begin
                r_win[k] <= 8'd0;
            end
            r_win[WIN_LEN - 1] <= WIN_LAST_RST;
            for (int m = 0; m < MOTORS; m++) begin
                r_motor[m] <= '{dir: DIR_RELEASED, speed: 8'd0};
            end
            r_res_valid <= 1'b0;
        end else begin
            if (w_rx_acc) begin
                r_win <= n_win;
                if (w_frame_ok) begin
                    r_motor <= n_motor;
                end
            end
            // new result replaces a drained one, else clear on drain
            if (w_rx_acc && w_frame_ok) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_rx_acc && w_frame_ok) begin
            r_out <= n_motor;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_dir_one     = r_out[0].dir;
    assign o_speed_one   = r_out[0].speed;
    assign o_dir_two     = r_out[1].dir;
    assign o_speed_two   = r_out[1].speed;
    assign o_dir_three   = r_out[2].dir;
    assign o_speed_three = r_out[2].speed;
    assign o_dir_four    = r_out[3].dir;
    assign o_speed_four  = r_out[3].speed;

    // every released motor sits at speed zero
    always_comb begin
        w_released_ok = 1'b1;
        for (int m = 0; m < MOTORS; m++) begin
            if (r_motor[m].dir == DIR_RELEASED && r_motor[m].speed != 8'd0) begin
                w_released_ok = 1'b0;
            end
        end
    end

    // a held result blocks new bytes
    `MCFD_ASSERT_IMP(a_hold_blocks_rx, i_clk, i_rst_n, r_res_valid && !i_res_ready, !o_rx_ready)

    // a good frame always lands in the result register
    `MCFD_ASSERT_NXT(a_frame_gives_result, i_clk, i_rst_n, w_rx_acc && w_frame_ok, r_res_valid)

    // a released motor always sits at speed zero
    `MCFD_ASSERT_IMP(a_released_stopped, i_clk, i_rst_n, 1'b1, w_released_ok)

endmodule

FILE: sim/motor_command_frame_decoder_test.sv
// testbench for the motor command frame decoder: byte stream in, decoded motor commands out
`timescale 1ns / 1ps

module motor_command_frame_decoder_test
    import mcfd_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    // ways a generated frame can be broken
    typedef enum int {
        FLAW_NONE  = 0,
        FLAW_CHECK = 1,
        FLAW_START = 2,
        FLAW_END   = 3,
        FLAW_DROP  = 4
    } t_flaw;

    // index 0 is motor one
    typedef t_motor [MOTORS-1:0] t_motor_set;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_addr  = CFG_START_MARKER;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_rx_valid  = 1'b0;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       o_res_valid;
    logic       i_res_ready = 1'b0;
    logic [1:0] o_dir_one;
    logic [7:0] o_speed_one;
    logic [1:0] o_dir_two;
    logic [7:0] o_speed_two;
    logic [1:0] o_dir_three;
    logic [7:0] o_speed_three;
    logic [1:0] o_dir_four;
    logic [7:0] o_speed_four;

    // shadow of the configuration registers
    logic [7:0] start_marker_q;
    logic [7:0] end_marker_q;
    logic [7:0] slow_speed_q;
    logic [7:0] fast_speed_q;

    // shadow of the receive window and the motor state
    logic [7:0] rx_window [WIN_LEN];
    t_motor_set motor_now;

    // motor commands decoded by the shadow and not yet seen at the output
    t_motor_set pending_motor_cmds [$];

    int    items_sent     = 0;
    int    frames_checked = 0;
    int    mismatches     = 0;
    int    settings_used  = 1;
    int    burst_left     = 0;
    int    cycle_count    = 0;
    int    stall_tick     = 0;
    string motor_names [MOTORS] = '{"one", "two", "three", "four"};

    motor_command_frame_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_dir_one     (o_dir_one),
        .o_speed_one   (o_speed_one),
        .o_dir_two     (o_dir_two),
        .o_speed_two   (o_speed_two),
        .o_dir_three   (o_dir_three),
        .o_speed_three (o_speed_three),
        .o_dir_four    (o_dir_four),
        .o_speed_four  (o_speed_four)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case a request or a result never shows up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $realtime, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure: rotates through always ready, coin flip,
    // mostly stalled and a fixed 3-of-8 pattern
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_tick[8:7])
            2'd0:    i_res_ready <= 1'b1;
            2'd1:    i_res_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_res_ready <= ($urandom_range(0, 3) == 0);
            default: i_res_ready <= (stall_tick[2:0] < 3);
        endcase
    end

    function automatic void reset_shadow();
        start_marker_q = START_MARKER_RST;
        end_marker_q   = END_MARKER_RST;
        slow_speed_q   = SLOW_SPEED_RST;
        fast_speed_q   = FAST_SPEED_RST;
        for (int k = 0; k < WIN_LEN; k++) rx_window[k] = 8'h00;
        rx_window[0]         = WIN_FIRST_RST;
        rx_window[WIN_LEN-1] = WIN_LAST_RST;
        for (int m = 0; m < MOTORS; m++) begin
            motor_now[m].dir   = DIR_RELEASED;
            motor_now[m].speed = 8'd0;
        end
    endfunction

    // shift one byte into the shadow window; on a good frame update the
    // motors and queue the command the block should emit
    function automatic void shift_and_decode(input logic [7:0] rx);
        logic [7:0] xor_sum;
        logic [7:0] mode_byte;
        logic [3:0] mode;
        logic [7:0] speed_byte;
        for (int k = 0; k < WIN_LEN - 1; k++) rx_window[k] = rx_window[k+1];
        rx_window[WIN_LEN-1] = rx;
        if (rx_window[0] != start_marker_q || rx_window[WIN_LEN-1] != end_marker_q) return;
        xor_sum = 8'h00;
        for (int k = 1; k <= 6; k++) xor_sum ^= rx_window[k];
        if (xor_sum != rx_window[7]) return;
        for (int m = 0; m < MOTORS; m++) begin
            // even motors take the high nibble of their mode byte
            mode_byte = rx_window[1 + m / 2];
            mode = (m % 2 == 0) ? mode_byte[7:4] : mode_byte[3:0];
            case (mode)
                MODE_RELEASE: begin
                    motor_now[m].dir = DIR_RELEASED; motor_now[m].speed = 8'd0;
                end
                MODE_FWD_STOP: begin
                    motor_now[m].dir = DIR_FORWARD; motor_now[m].speed = 8'd0;
                end
                MODE_FWD_SLOW: begin
                    motor_now[m].dir = DIR_FORWARD; motor_now[m].speed = slow_speed_q;
                end
                MODE_FWD_FAST: begin
                    motor_now[m].dir = DIR_FORWARD; motor_now[m].speed = fast_speed_q;
                end
                MODE_BWD_STOP: begin
                    motor_now[m].dir = DIR_BACKWARD; motor_now[m].speed = 8'd0;
                end
                MODE_BWD_SLOW: begin
                    motor_now[m].dir = DIR_BACKWARD; motor_now[m].speed = slow_speed_q;
                end
                MODE_BWD_FAST: begin
                    motor_now[m].dir = DIR_BACKWARD; motor_now[m].speed = fast_speed_q;
                end
                default: ; // unknown mode keeps the motor as it was
            endcase
            // nonzero speed byte wins unless the motor is released
            speed_byte = rx_window[3 + m];
            if (speed_byte != 8'd0 && motor_now[m].dir != DIR_RELEASED) begin
                motor_now[m].speed = speed_byte;
            end
        end
        pending_motor_cmds.push_back(motor_now);
    endfunction

    // one rx request; the sender runs in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (!o_rx_ready);
        shift_and_decode(rx);
        items_sent++;
    endtask

    // compare every accepted result with the oldest queued command
    always @(posedge i_clk) begin : check_results
        t_motor_set want;
        t_motor_set got;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got[0].dir = o_dir_one;   got[0].speed = o_speed_one;
            got[1].dir = o_dir_two;   got[1].speed = o_speed_two;
            got[2].dir = o_dir_three; got[2].speed = o_speed_three;
            got[3].dir = o_dir_four;  got[3].speed = o_speed_four;
            if (pending_motor_cmds.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got %h", $realtime, got);
            end else begin
                want = pending_motor_cmds.pop_front();
                frames_checked++;
                for (int m = 0; m < MOTORS; m++) begin
                    if (got[m].dir !== want[m].dir) begin
                        mismatches++;
                        $display("%0t: dir_%s expected %0d got %0d", $realtime,
                                 motor_names[m], want[m].dir, got[m].dir);
                    end
                    if (got[m].speed !== want[m].speed) begin
                        mismatches++;
                        $display("%0t: speed_%s expected %0d got %0d", $realtime,
                                 motor_names[m], want[m].speed, got[m].speed);
                    end
                end
            end
        end
    end

    // stop sending and wait until every queued command has come out
    task automatic drain();
        i_rx_valid <= 1'b0;
        while (pending_motor_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            CFG_START_MARKER: start_marker_q = data;
            CFG_END_MARKER:   end_marker_q   = data;
            CFG_SLOW_SPEED:   slow_speed_q   = data;
            default:          fast_speed_q   = data;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] start_m, input logic [7:0] end_m,
                              input logic [7:0] slow, input logic [7:0] fast);
        drain();
        write_reg(CFG_START_MARKER, start_m);
        write_reg(CFG_END_MARKER, end_m);
        write_reg(CFG_SLOW_SPEED, slow);
        write_reg(CFG_FAST_SPEED, fast);
        settings_used++;
    endtask

    // modes: motor one in the top nibble; speeds: motor one in the top byte
    task automatic send_frame(input logic [15:0] modes, input logic [31:0] speeds,
                              input t_flaw flaw);
        logic [7:0] fr [WIN_LEN];
        logic [7:0] nz;
        nz    = 8'($urandom_range(1, 255));
        fr[0] = start_marker_q;
        fr[1] = modes[15:8];
        fr[2] = modes[7:0];
        fr[3] = speeds[31:24];
        fr[4] = speeds[23:16];
        fr[5] = speeds[15:8];
        fr[6] = speeds[7:0];
        fr[7] = fr[1] ^ fr[2] ^ fr[3] ^ fr[4] ^ fr[5] ^ fr[6];
        fr[8] = end_marker_q;
        case (flaw)
            FLAW_CHECK: fr[7] ^= nz;
            FLAW_START: fr[0] ^= nz;
            FLAW_END:   fr[8] ^= nz;
            default: ;
        endcase
        for (int k = 0; k < WIN_LEN; k++) begin
            // a dropped byte leaves a short frame
            if (!(flaw == FLAW_DROP && k == 4)) send_byte(fr[k]);
        end
    endtask

    // mostly known modes, some unknown ones
    function automatic logic [3:0] pick_mode();
        if ($urandom_range(0, 4) == 0) return 4'($urandom_range(MODE_BWD_FAST + 1, 15));
        return 4'($urandom_range(MODE_RELEASE, MODE_BWD_FAST));
    endfunction

    function automatic logic [7:0] pick_speed();
        if ($urandom_range(0, 1) == 0) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed frames with random content, broken frames and loose noise
    task automatic run_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame({pick_mode(), pick_mode(), pick_mode(), pick_mode()},
                           {pick_speed(), pick_speed(), pick_speed(), pick_speed()},
                           FLAW_NONE);
            end else if (pick < 85) begin
                send_frame({pick_mode(), pick_mode(), pick_mode(), pick_mode()},
                           {pick_speed(), pick_speed(), pick_speed(), pick_speed()},
                           t_flaw'($urandom_range(FLAW_CHECK, FLAW_DROP)));
            end else begin
                // noise, sometimes a stray start marker to fake a frame start
                repeat ($urandom_range(1, 6)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? start_marker_q
                                                          : 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // every mode, unknown modes on live motors, speed override rules and a bad
    // check byte, all at the reset register values
    task automatic test_reset_decode();
        // released motor ignores its speed byte, zero speed bytes keep presets
        send_frame({MODE_RELEASE, MODE_FWD_STOP, MODE_FWD_SLOW, MODE_FWD_FAST},
                   32'hFF_00_00_00, FLAW_NONE);
        // backward modes; motor four keeps forward fast and takes its speed byte
        send_frame({MODE_BWD_STOP, MODE_BWD_SLOW, MODE_BWD_FAST, 4'hF},
                   32'h01_00_00_7E, FLAW_NONE);
        // bad check byte: no result and motor state must not move
        send_frame({4'h7, 4'h8, MODE_RELEASE, 4'hC}, 32'h00_22_33_44, FLAW_CHECK);
    endtask

    // marker and speed registers at their extremes
    task automatic test_register_extremes();
        set_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        run_traffic(250);
        set_config(8'hFF, 8'h00, 8'hFF, 8'h00);
        run_traffic(250);
    endtask

    // start and end marker equal, so overlapping windows can line up
    task automatic test_shared_marker();
        set_config(8'h5A, 8'h5A, 8'h01, 8'hFE);
        run_traffic(200);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_traffic(200);
        end
    endtask

    task automatic test_back_to_defaults();
        set_config(START_MARKER_RST, END_MARKER_RST, SLOW_SPEED_RST, FAST_SPEED_RST);
        run_traffic(200);
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_decode();
        test_register_extremes();
        test_shared_marker();
        test_random_settings();
        test_back_to_defaults();
        drain();

        $display("sent %0d rx bytes under %0d register settings, %0d frames decoded",
                 items_sent, settings_used, frames_checked);
        $display("field mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
